// ===== rtl/vtd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_pkg: shared types and constants of the vertex tuple dedup table
// Field widths, hash constants, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vtd_pkg;

  // fixed field widths
  localparam int VNUM_W       = 10;
  localparam int LEN_W        = 3;
  localparam int TUPLE_FIELDS = 4;

  // polynomial hash, wraps at 64 bits
  localparam int              HASH_W     = 64;
  localparam logic [HASH_W-1:0] HASH_PRIME = 64'd13931;

  localparam logic [LEN_W-1:0] LEN_RESET = 3'd3;

  // parameter defaults
  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_INDEX_BITS = 24;
  localparam int DEF_MAX_TUPLE  = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_SEED,
    ST_READ,
    ST_CHECK
  } state_e;

  typedef enum logic [1:0] {
    RES_HIT,
    RES_NEW,
    RES_OVF
  } res_e;

  typedef struct packed {
    logic clear;      // zero one table entry
    logic accept;     // capture a new request
    logic hash_step;  // fold one component into the hash
    logic mod_step;   // one step of the bucket remainder
    logic seed;       // load the home bucket
    logic rd_en;      // read the table at the probe slot
    logic advance;    // step to the next slot
    logic insert;     // write the new tuple at the probe slot
    logic out_load;   // load the output register
    res_e res;        // kind of result to load
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic mod_last;
    logic need_mod;
    logic empty;
    logic match;
    logic full;
    logic probe_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/vtd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_ctrl: sequencing controller
// Clears the table after reset, then per request runs the hash, locates
// the home bucket and walks the probe sequence until a hit, a free slot or
// every slot of the table has been probed.
// ----------------------------------------------------------------------------
module vtd_ctrl
  import vtd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) state_d = sts_i.need_mod ? ST_MOD : ST_SEED;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = ST_SEED;
      end
      ST_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        // once a result is ready, hold here until the output register can take it
        priority if (sts_i.empty) begin
          cmd_o.res = sts_i.full ? RES_OVF : RES_NEW;
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.insert   = !sts_i.full;
            state_d        = ST_IDLE;
          end
        end else if (sts_i.match) begin
          cmd_o.res = RES_HIT;
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else if (sts_i.probe_last) begin
          cmd_o.res = RES_OVF;
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_READ;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/vtd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_datapath: hash unit, probe registers, table memory and output register
// The table is one memory of words {valid, number, keys}, one write and one
// registered read per cycle. When the capacity is not a power of two the
// home bucket comes from a four-step unit: hash bytes folded by their
// residues, a reciprocal quotient estimate, a subtract and one correction.
// ----------------------------------------------------------------------------
module vtd_datapath
  import vtd_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  parameter int MAX_TUPLE  = DEF_MAX_TUPLE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LEN_W-1:0]      cfg_wdata_i,
  input  logic [INDEX_BITS-1:0] index_a_i,
  input  logic [INDEX_BITS-1:0] index_b_i,
  input  logic [INDEX_BITS-1:0] index_c_i,
  input  logic [INDEX_BITS-1:0] index_d_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [VNUM_W-1:0]     vertex_number_o,
  output logic                  is_new_o,
  output logic                  overflow_o
);

  localparam int  KEYS    = (MAX_TUPLE < TUPLE_FIELDS) ? MAX_TUPLE : TUPLE_FIELDS;
  localparam int  SLOT_W  = $clog2(CAPACITY);
  localparam int  CNT_W   = $clog2(CAPACITY + 1);
  localparam int  KEY_W   = KEYS * INDEX_BITS;
  localparam int  WORD_W  = 1 + VNUM_W + KEY_W;
  localparam int  MCNT_W  = 2;
  localparam bit  IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int  FOLD_W  = 28;
  localparam int  HASH_BYTES = HASH_W / 8;

  localparam logic [HASH_W-1:0] CAP_H = HASH_W'(CAPACITY);

  // 2^(8*j) mod CAPACITY for each hash byte
  localparam logic [16:0] BYTE_RES [HASH_BYTES] = '{
    17'(64'd1 % CAP_H),         17'((64'd1 << 8) % CAP_H),
    17'((64'd1 << 16) % CAP_H), 17'((64'd1 << 24) % CAP_H),
    17'((64'd1 << 32) % CAP_H), 17'((64'd1 << 40) % CAP_H),
    17'((64'd1 << 48) % CAP_H), 17'((64'd1 << 56) % CAP_H)
  };

  // floor(2^32 / CAPACITY)
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / CAP_H);

  typedef logic [KEYS-1:0][INDEX_BITS-1:0] keys_t;

  logic [LEN_W-1:0]      cfg_len_q;
  logic [LEN_W-1:0]      eff_len;
  logic [INDEX_BITS-1:0] in_key [TUPLE_FIELDS];
  keys_t                 key_q, sh_q, rd_keys;
  logic [LEN_W-1:0]      len_q, left_q;
  logic [HASH_W-1:0]     h_q;
  logic [SLOT_W-1:0]     rem_q, home;
  logic [FOLD_W-1:0]     fold_q, fold_d, quo_q, diff_full;
  logic [FOLD_W+31:0]    recip_prod;
  logic [SLOT_W:0]       diff_q;
  logic [MCNT_W-1:0]     mcnt_q;
  logic [SLOT_W-1:0]     slot_q, clr_q;
  logic [CNT_W-1:0]      probe_q, count_q;
  logic [WORD_W-1:0]     mem_q [CAPACITY];
  logic [WORD_W-1:0]     rd_q, new_word;
  logic                  rd_valid, key_eq, full;
  logic [VNUM_W-1:0]     rd_num;
  logic                  out_valid_q, out_free;

  // length register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  // clamp length into 1..KEYS
  always_comb begin
    if (cfg_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_len_q > LEN_W'(KEYS)) begin
      eff_len = LEN_W'(KEYS);
    end else begin
      eff_len = cfg_len_q;
    end
  end

  assign in_key[0] = index_a_i;
  assign in_key[1] = index_b_i;
  assign in_key[2] = index_c_i;
  assign in_key[3] = index_d_i;

  // bucket remainder: byte residues summed, below 2^28
  always_comb begin
    fold_d = '0;
    for (int j = 0; j < HASH_BYTES; j++) begin
      fold_d = fold_d + FOLD_W'(h_q[8*j +: 8]) * FOLD_W'(BYTE_RES[j]);
    end
  end

  // quotient estimate is exact or one low, so the difference is below 2*CAPACITY
  assign recip_prod = (FOLD_W + 32)'(fold_q) * (FOLD_W + 32)'(RECIP);
  assign diff_full  = fold_q - quo_q * FOLD_W'(CAPACITY);

  assign home = IS_POW2 ? h_q[SLOT_W-1:0] : rem_q;

  // request capture, hash chain and remainder
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int i = 0; i < KEYS; i++) begin
        key_q[i] <= (LEN_W'(i) < eff_len) ? in_key[i] : '0;
        sh_q[i]  <= (LEN_W'(i) < eff_len) ? in_key[i] : '0;
      end
      len_q  <= eff_len;
      left_q <= eff_len;
      h_q    <= '0;
      rem_q  <= '0;
      mcnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      h_q <= h_q * HASH_PRIME + HASH_W'(sh_q[0]);
      for (int i = 0; i < KEYS - 1; i++) sh_q[i] <= sh_q[i+1];
      sh_q[KEYS-1] <= '0;
      left_q       <= left_q - 1'b1;
    end else if (cmd_i.mod_step) begin
      // four-stage chain, settled after the fourth step
      fold_q <= fold_d;
      quo_q  <= recip_prod[FOLD_W+31:32];
      diff_q <= diff_full[SLOT_W:0];
      rem_q  <= (diff_q >= (SLOT_W + 1)'(CAPACITY)) ?
                SLOT_W'(diff_q - (SLOT_W + 1)'(CAPACITY)) : diff_q[SLOT_W-1:0];
      mcnt_q <= mcnt_q + 1'b1;
    end
  end

  // probe slot and probe count
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed) begin
      slot_q  <= home;
      probe_q <= '0;
    end else if (cmd_i.advance) begin
      slot_q  <= (slot_q == SLOT_W'(CAPACITY - 1)) ? '0 : slot_q + 1'b1;
      probe_q <= probe_q + 1'b1;
    end
  end

  // clearing pointer and assigned count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.clear)  clr_q   <= clr_q + 1'b1;
      if (cmd_i.insert) count_q <= count_q + 1'b1;
    end
  end

  assign new_word = {1'b1, VNUM_W'(count_q), key_q};

  // table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.insert) begin
      mem_q[slot_q] <= new_word;
    end
    if (cmd_i.rd_en) rd_q <= mem_q[slot_q];
  end

  assign rd_valid = rd_q[WORD_W-1];
  assign rd_num   = rd_q[WORD_W-2 -: VNUM_W];
  assign rd_keys  = rd_q[KEY_W-1:0];

  // compare the components in use
  always_comb begin
    key_eq = 1'b1;
    for (int i = 0; i < KEYS; i++) begin
      if ((LEN_W'(i) < len_q) && (rd_keys[i] != key_q[i])) key_eq = 1'b0;
    end
  end

  assign full     = count_q == CNT_W'(CAPACITY);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o            = '0;
    sts_o.clear_last = clr_q == SLOT_W'(CAPACITY - 1);
    sts_o.hash_last  = left_q == LEN_W'(1);
    sts_o.mod_last   = mcnt_q == '1;
    sts_o.need_mod   = !IS_POW2;
    sts_o.empty      = !rd_valid;
    sts_o.match      = rd_valid && key_eq;
    sts_o.full       = full;
    sts_o.probe_last = probe_q == CNT_W'(CAPACITY - 1);
    sts_o.out_free   = out_free;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.res)
        RES_HIT: begin
          vertex_number_o <= rd_num;
          is_new_o        <= 1'b0;
          overflow_o      <= 1'b0;
        end
        RES_NEW: begin
          vertex_number_o <= VNUM_W'(count_q);
          is_new_o        <= 1'b1;
          overflow_o      <= 1'b0;
        end
        RES_OVF: begin
          vertex_number_o <= '0;
          is_new_o        <= 1'b0;
          overflow_o      <= 1'b1;
        end
        default: begin
          vertex_number_o <= '0;
          is_new_o        <= 1'b0;
          overflow_o      <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/vertex_tuple_dedup_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_tuple_dedup_table_top: face-corner tuple deduplication table
//
//   channel   direction  handshake               payload
//   config    in         cfg_we_i                cfg_wdata_i (tuple_length)
//   request   in         in_valid_i / in_stall_o index_a_i .. index_d_i
//   result    out        out_valid_o/out_stall_i vertex_number_o, is_new_o,
//                                                overflow_o
//
// One request at a time. Each request hashes its L components, forms the
// bucket remainder when CAPACITY is not a power of two, seeds the home
// bucket and then reads and checks one table slot per probe (P probes).
// The probe loop is bound by the single registered read of the table.
// After reset the table is cleared one entry per cycle, all CAPACITY
// entries, with in_stall_o high. A stalled result is held in the output
// register while the next request is already accepted and processed.
// ----------------------------------------------------------------------------
module vertex_tuple_dedup_table_top
  import vtd_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  parameter int MAX_TUPLE  = DEF_MAX_TUPLE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LEN_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [INDEX_BITS-1:0] index_a_i,
  input  logic [INDEX_BITS-1:0] index_b_i,
  input  logic [INDEX_BITS-1:0] index_c_i,
  input  logic [INDEX_BITS-1:0] index_d_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VNUM_W-1:0]     vertex_number_o,
  output logic                  is_new_o,
  output logic                  overflow_o
);

  cmd_t cmd;
  sts_t sts;

  vtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vtd_datapath #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS),
    .MAX_TUPLE  (MAX_TUPLE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .index_a_i       (index_a_i),
    .index_b_i       (index_b_i),
    .index_c_i       (index_c_i),
    .index_d_i       (index_d_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .vertex_number_o (vertex_number_o),
    .is_new_o        (is_new_o),
    .overflow_o      (overflow_o)
  );

endmodule

// ===== rtl/vtd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_checker: port-level checks of the dedup table
// Result handshake and result coding, plus one request at a time.
// ----------------------------------------------------------------------------
module vtd_checker
  import vtd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [VNUM_W-1:0] vertex_number_o,
  input logic              is_new_o,
  input logic              overflow_o
);

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(vertex_number_o) && $stable(is_new_o) && $stable(overflow_o))
    else $error("stalled result changed");

  // new and overflow exclude each other
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && overflow_o))
    else $error("result flagged both new and overflow");

  // an overflow result carries number zero
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> vertex_number_o == '0)
    else $error("overflow result with nonzero number");

  // after a request is taken the block is busy with it
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

endmodule

bind vertex_tuple_dedup_table_top vtd_checker u_checker (.*);

// ===== tb/vertex_tuple_dedup_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_tuple_dedup_table_top_tb: self-checking bench for the dedup table
// Drives face-corner tuples through the request channel under random source
// gaps and result stalls. A behavioral copy of the hash table predicts the
// vertex number and flags of every accepted request, and each accepted result
// is checked against the oldest prediction. Covers every tuple length
// including out-of-range codes, bucket collisions and wrap, length changes
// over a live table and a long result hold-off.
// ----------------------------------------------------------------------------
module vertex_tuple_dedup_table_top_tb;
  import vtd_pkg::*;

  localparam int CAPACITY   = DEF_CAPACITY;
  localparam int INDEX_BITS = DEF_INDEX_BITS;
  localparam int MAX_TUPLE  = DEF_MAX_TUPLE;

  // slowest step: a probe over the full table, a read and a check per slot,
  // plus a long stall on either side; taken several times over
  localparam int QUIET_LIMIT     = 12000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 63;

  typedef logic [TUPLE_FIELDS-1:0][INDEX_BITS-1:0] corner_t;

  typedef struct {
    logic [VNUM_W-1:0] vnum;
    logic              is_new;
    logic              overflow;
  } vertex_result_t;

  logic                  clk = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [LEN_W-1:0]      cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [INDEX_BITS-1:0] index_a_i;
  logic [INDEX_BITS-1:0] index_b_i;
  logic [INDEX_BITS-1:0] index_c_i;
  logic [INDEX_BITS-1:0] index_d_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [VNUM_W-1:0]     vertex_number_o;
  logic                  is_new_o;
  logic                  overflow_o;

  // behavioral copy of the table
  logic [LEN_W-1:0]  model_length;
  corner_t           stored_corner [CAPACITY];
  logic [VNUM_W-1:0] stored_number [CAPACITY];
  bit                slot_used [CAPACITY];
  int unsigned       vertex_count;

  vertex_result_t pending_vertices [$];
  corner_t        corner_pool [$];

  int unsigned fail_count  = 0;
  int unsigned quiet_count = 0;
  bit          src_jitter   = 1'b0;
  bit          sink_jitter  = 1'b0;
  bit          hold_off_req = 1'b0;

  vertex_tuple_dedup_table_top #(
    .CAPACITY  (CAPACITY),
    .INDEX_BITS(INDEX_BITS),
    .MAX_TUPLE (MAX_TUPLE)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .index_a_i      (index_a_i),
    .index_b_i      (index_b_i),
    .index_c_i      (index_c_i),
    .index_d_i      (index_d_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_number_o(vertex_number_o),
    .is_new_o       (is_new_o),
    .overflow_o     (overflow_o)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned active_length();
    int unsigned top;
    int unsigned n;
    top = (MAX_TUPLE < TUPLE_FIELDS) ? MAX_TUPLE : TUPLE_FIELDS;
    n   = model_length;
    if (n < 1) n = 1;
    if (n > top) n = top;
    return n;
  endfunction

  // look up one tuple, inserting it when not yet stored
  function automatic vertex_result_t dedup_lookup(input corner_t c);
    corner_t           key;
    logic [HASH_W-1:0] h;
    int unsigned       len;
    int unsigned       slot;
    bit                same;
    vertex_result_t    r;
    len = active_length();
    key = '0;
    h   = '0;
    for (int i = 0; i < len; i++) begin
      key[i] = c[i];
      h      = h * HASH_PRIME + HASH_W'(c[i]);
    end
    slot       = int'(h % HASH_W'(CAPACITY));
    r.vnum     = '0;
    r.is_new   = 1'b0;
    r.overflow = 1'b1;
    for (int probe = 0; probe < CAPACITY; probe++) begin
      if (!slot_used[slot]) begin
        if (vertex_count >= CAPACITY) break;
        stored_corner[slot] = key;
        stored_number[slot] = VNUM_W'(vertex_count);
        slot_used[slot]     = 1'b1;
        r.vnum              = VNUM_W'(vertex_count);
        r.is_new            = 1'b1;
        r.overflow          = 1'b0;
        vertex_count++;
        return r;
      end
      same = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (stored_corner[slot][i] != key[i]) same = 1'b0;
      end
      if (same) begin
        r.vnum     = stored_number[slot];
        r.overflow = 1'b0;
        return r;
      end
      slot = (slot + 1) % CAPACITY;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
  endfunction

  function automatic corner_t make_corner(input logic [INDEX_BITS-1:0] a,
                                          input logic [INDEX_BITS-1:0] b,
                                          input logic [INDEX_BITS-1:0] c,
                                          input logic [INDEX_BITS-1:0] d);
    return {d, c, b, a};
  endfunction

  // mix of zeros, all-ones, small values (frequent repeats) and full random
  function automatic corner_t fresh_corner();
    corner_t c;
    for (int i = 0; i < TUPLE_FIELDS; i++) begin
      case ($urandom_range(0, 5))
        0:       c[i] = '0;
        1:       c[i] = '1;
        2, 3:    c[i] = INDEX_BITS'($urandom_range(0, 15));
        default: c[i] = INDEX_BITS'($urandom);
      endcase
    end
    return c;
  endfunction

  // present one request and hold it until accepted
  task automatic offer_corner(input corner_t c);
    int unsigned gap;
    @(negedge clk);
    in_valid_i <= 1'b1;
    index_a_i  <= c[0];
    index_b_i  <= c[1];
    index_c_i  <= c[2];
    index_d_i  <= c[3];
    do @(posedge clk); while (in_stall_o);
    pending_vertices.insert(pending_vertices.size(), dedup_lookup(c));
    corner_pool.insert(corner_pool.size(), c);
    if (src_jitter && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      @(negedge clk);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid, then wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
  endtask

  task automatic set_tuple_length(input logic [LEN_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk);
    cfg_we_i     <= 1'b0;
    model_length  = value;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    // reset length of three; unused fourth component must be ignored
    offer_corner(make_corner('0, '0, '0, '1));
    offer_corner(make_corner('1, '1, '1, '0));
    offer_corner(make_corner('0, '0, '0, 24'd123));
    offer_corner(make_corner(24'd1, 24'd2, 24'd3, '0));
    // single component: the all-zero entry matches on a alone
    set_tuple_length(3'd1);
    offer_corner(make_corner('0, INDEX_BITS'($urandom), INDEX_BITS'($urandom), '1));
    // same bucket three times, then a hit deep in the chain
    offer_corner(make_corner(24'd7, '0, '0, '0));
    offer_corner(make_corner(24'd7 + 24'd1024, '0, '0, '0));
    offer_corner(make_corner(24'd7 + 24'd2048, '0, '0, '0));
    offer_corner(make_corner(24'd7 + 24'd1024, '1, '1, '1));
    // last bucket, probe wraps to the start of the table
    offer_corner(make_corner(24'd1023, '0, '0, '0));
    offer_corner(make_corner(24'd1023 + 24'd1024, '0, '0, '0));
    offer_corner(make_corner('1, '0, '0, '0));
    // four components against entries stored with zero padding
    set_tuple_length(3'd4);
    offer_corner(make_corner('0, '0, '0, '0));
    offer_corner(make_corner('0, '0, '0, 24'd1));
    offer_corner(make_corner('1, '1, '1, '1));
    set_tuple_length(3'd2);
    offer_corner(make_corner(24'd5, 24'd6, INDEX_BITS'($urandom), '1));
    offer_corner(make_corner(24'd5, 24'd6, '0, INDEX_BITS'($urandom)));
    // out-of-range codes: zero acts as one, above four acts as four
    set_tuple_length(3'd0);
    offer_corner(make_corner(24'd5, '0, '0, '0));
    offer_corner(make_corner(24'd5, '1, '1, '1));
    set_tuple_length(3'd7);
    offer_corner(make_corner(24'd1, 24'd2, 24'd3, '0));
    offer_corner(make_corner(24'd9, 24'd9, 24'd9, 24'd9));
    offer_corner(make_corner(24'd9, 24'd9, 24'd9, 24'd9));
    set_tuple_length(3'd5);
    offer_corner(make_corner(24'd9, 24'd9, 24'd9, 24'd9));
    set_tuple_length(3'd6);
    offer_corner(make_corner(24'd9, 24'd9, 24'd9, 24'd9));
  endtask

  task automatic test_random_traffic();
    logic [LEN_W-1:0] phase_len [8];
    corner_t          c;
    int unsigned      sel;
    int unsigned      k;
    phase_len = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6};
    for (int p = 0; p < 8; p++) begin
      set_tuple_length(phase_len[p]);
      src_jitter  = (p % 3 != 2);
      sink_jitter = (p % 4 != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
          // repeat of an earlier tuple, noise on unused components
          c = corner_pool[$urandom_range(0, corner_pool.size() - 1)];
          for (int i = active_length(); i < TUPLE_FIELDS; i++) c[i] = INDEX_BITS'($urandom);
        end else if (sel < 6) begin
          // near miss: one used bit flipped
          c = corner_pool[$urandom_range(0, corner_pool.size() - 1)];
          k = $urandom_range(0, active_length() - 1);
          c[k] = c[k] ^ INDEX_BITS'(1 << $urandom_range(0, INDEX_BITS - 1));
        end else begin
          c = fresh_corner();
        end
        offer_corner(c);
      end
    end
  endtask

  task automatic test_backpressure();
    set_tuple_length(3'd3);
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    // receiver holds off while requests keep coming: block fills and stalls
    hold_off_req = 1'b1;
    for (int n = 0; n < 8; n++) offer_corner(fresh_corner());
    // source pauses for a full drain, then resumes
    wait_drained();
    for (int n = 0; n < 8; n++) offer_corner(corner_pool[$urandom_range(0, corner_pool.size() - 1)]);
    wait_drained();
  endtask

  // ---------------------------------------------------------------- result side

  // stall driver: random gaps, or one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left   = 0;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (sink_jitter && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    vertex_result_t exp;
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_vertices.size() == 0) begin
        $error("result with no request pending: vertex_number %0d", vertex_number_o);
        fail_count++;
      end else begin
        exp = pending_vertices.pop_front();
        if (vertex_number_o !== exp.vnum) begin
          $error("vertex_number: expected %0d, actual %0d", exp.vnum, vertex_number_o);
          fail_count++;
        end
        if (is_new_o !== exp.is_new) begin
          $error("is_new: expected %0d, actual %0d", exp.is_new, is_new_o);
          fail_count++;
        end
        if (overflow_o !== exp.overflow) begin
          $error("overflow: expected %0d, actual %0d", exp.overflow, overflow_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : test_sequence
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    index_a_i   = '0;
    index_b_i   = '0;
    index_c_i   = '0;
    index_d_i   = '0;
    model_length = LEN_RESET;
    vertex_count = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_backpressure();

    // let any stray result show up
    wait_drained();
    repeat (64) @(posedge clk);
    if (pending_vertices.size() != 0) begin
      $error("%0d results never arrived", pending_vertices.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vtd_pkg.sv
rtl/vtd_ctrl.sv
rtl/vtd_datapath.sv
rtl/vertex_tuple_dedup_table_top.sv
rtl/vtd_checker.sv
tb/vertex_tuple_dedup_table_top_tb.sv
